// ----- hdl/sti_pkg.sv -----
// ----------------------------------------------------------------------------
// sti_pkg: shared types and constants of the sorted table
// Widths, operation and status codes, controller states and the control
// group that steps the table store.
// ----------------------------------------------------------------------------
package sti_pkg;

   // table geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   // item field widths
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CAP_W      = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // register index, taken from the word address bit
   localparam logic CSR_REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_BAD_INDEX = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_SCAN,
      S_INS_HEAD,
      S_DEL_SCAN,
      S_RD_WAIT
   } state_type;

   // one read and one write of the table per cycle
   typedef struct packed {
      logic                      rd_en;
      logic [IDX_W-1:0]          rd_addr;
      logic                      wr_en;
      logic [IDX_W-1:0]          wr_addr;
      logic signed [VALUE_W-1:0] wr_data;
   } tbl_ctrl_type;

   // shared comparator flags, entry against the key
   typedef struct packed {
      logic less;
      logic equal;
   } cmp_type;

endpackage

// ----- hdl/sti_if.sv -----
// ----------------------------------------------------------------------------
// sti_if: item channels of the sorted table
// Request channel with operation, value and index; response channel with
// count, read value and status. Valid/ready handshake.
// ----------------------------------------------------------------------------
interface sti_req_if;
   logic                               valid;
   logic                               ready;
   sti_pkg::opcode_type                opcode;
   logic signed [sti_pkg::VALUE_W-1:0] value;
   logic [sti_pkg::INDEX_W-1:0]        index;

   modport source (output valid, opcode, value, index, input ready);
   modport sink   (input valid, opcode, value, index, output ready);
endinterface

interface sti_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sti_pkg::COUNT_W-1:0]        count;
   logic signed [sti_pkg::VALUE_W-1:0] read_value;
   sti_pkg::status_type                status;

   modport source (output valid, count, read_value, status, input ready);
   modport sink   (input valid, count, read_value, status, output ready);
endinterface

// ----- hdl/sorted_table_insert_delete.sv -----
// An insert with room into a non-empty table scans back through S_INS_SCAN,
// then S_INS_HEAD if the value goes first; delete scans min(count, usable
// capacity) entries; read waits in S_RD_WAIT; others finish on acceptance.
// Throughput: one item at a time, the next item is accepted in the cycle its
// result is taken; the scan moves one entry per cycle through the memory port.
// Reset clears the count and the result valid and sets capacity to 16.
// ----------------------------------------------------------------------------
// sorted_table_insert_delete: ascending table of signed values
// Insert keeps order by shifting entries not below it up in a backward scan,
// delete compacts in a forward scan, read returns one entry.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete (
   input  logic                             clock,
   input  logic                             reset,
   sti_req_if.sink                          req_chan,
   sti_rsp_if.source                        rsp_chan,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sti_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [sti_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [sti_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import sti_pkg::*;

   state_type                 state_ff, state_in;
   logic [CAP_W-1:0]          cap_ff, cap_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [IDX_W-1:0]          ptr_ff, ptr_in;
   logic [IDX_W-1:0]          last_ff, last_in;
   logic [CNT_W-1:0]          kept_ff, kept_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [VALUE_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   status_type                rsp_status_ff, rsp_status_in;

   tbl_ctrl_type              ctrl;
   cmp_type                   cmp;
   logic signed [VALUE_W-1:0] rd_data;

   logic                      req_accept;
   logic                      rsp_take;
   logic                      csr_write;
   logic [CNT_W-1:0]          ucap;
   logic [CNT_W-1:0]          lim;
   logic [CNT_W-1:0]          kept_next;
   logic                      finish;
   status_type                fin_status;
   logic signed [VALUE_W-1:0] fin_rd;

   // entry store with the shared comparator
   sti_table u_table (
      .clock   (clock),
      .ctrl    (ctrl),
      .key     (value_ff),
      .rd_data (rd_data),
      .cmp     (cmp)
   );

   // handshakes
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign rsp_take       = rsp_valid_ff && rsp_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.count      = rsp_count_ff;
   assign rsp_chan.read_value = rsp_read_value_ff;
   assign rsp_chan.status     = rsp_status_ff;

   // capacity register
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_W-1] == CSR_REG_CAPACITY);
   assign cap_in     = csr_write ? csr_pwdata[CAP_W-1:0] : cap_ff;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == CSR_REG_CAPACITY)
                       ? CSR_DATA_W'(cap_ff) : '0;

   // usable capacity and delete scan limit
   assign ucap = (32'(cap_ff) >= DEPTH) ? CNT_W'(DEPTH) : CNT_W'(cap_ff);
   assign lim  = (count_ff < ucap) ? count_ff : ucap;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      last_in       = last_ff;
      kept_in       = kept_ff;
      kept_next     = kept_ff;
      value_in      = value_ff;
      ctrl          = '0;
      ctrl.wr_data  = value_ff;
      finish        = 1'b0;
      fin_status    = STAT_OK;
      fin_rd        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               value_in = req_chan.value;
               unique case (req_chan.opcode)
                  OP_INSERT: begin
                     if (count_ff >= ucap) begin
                        finish     = 1'b1;
                        fin_status = STAT_FULL;
                     end else if (count_ff == '0) begin
                        ctrl.wr_en   = 1'b1;
                        ctrl.wr_addr = '0;
                        ctrl.wr_data = req_chan.value;
                        count_in     = count_ff + CNT_W'(1);
                        finish       = 1'b1;
                     end else begin
                        ctrl.rd_en   = 1'b1;
                        ctrl.rd_addr = IDX_W'(count_ff - CNT_W'(1));
                        ptr_in       = IDX_W'(count_ff - CNT_W'(1));
                        state_in     = S_INS_SCAN;
                     end
                  end
                  OP_DELETE: begin
                     if (lim == '0) begin
                        count_in = '0;
                        finish   = 1'b1;
                     end else begin
                        ctrl.rd_en   = 1'b1;
                        ctrl.rd_addr = '0;
                        ptr_in       = '0;
                        last_in      = IDX_W'(lim - CNT_W'(1));
                        kept_in      = '0;
                        state_in     = S_DEL_SCAN;
                     end
                  end
                  OP_READ: begin
                     if ((32'(req_chan.index) < 32'(count_ff))
                         && (32'(req_chan.index) < DEPTH)) begin
                        ctrl.rd_en   = 1'b1;
                        ctrl.rd_addr = IDX_W'(req_chan.index);
                        state_in     = S_RD_WAIT;
                     end else begin
                        finish     = 1'b1;
                        fin_status = STAT_BAD_INDEX;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end

         // backward scan: shift entries not below the value up until the slot is found
         S_INS_SCAN: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = ptr_ff + IDX_W'(1);
            if (cmp.less) begin
               ctrl.wr_data = value_ff;
               count_in     = count_ff + CNT_W'(1);
               finish       = 1'b1;
               state_in     = S_IDLE;
            end else begin
               ctrl.wr_data = rd_data;
               if (ptr_ff == '0) begin
                  state_in = S_INS_HEAD;
               end else begin
                  ctrl.rd_en   = 1'b1;
                  ctrl.rd_addr = ptr_ff - IDX_W'(1);
                  ptr_in       = ptr_ff - IDX_W'(1);
               end
            end
         end

         // new value goes to the front
         S_INS_HEAD: begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_addr = '0;
            ctrl.wr_data = value_ff;
            count_in     = count_ff + CNT_W'(1);
            finish       = 1'b1;
            state_in     = S_IDLE;
         end

         // forward scan: keep unequal entries packed from the bottom
         S_DEL_SCAN: begin
            if (!cmp.equal) begin
               ctrl.wr_en   = 1'b1;
               ctrl.wr_addr = IDX_W'(kept_ff);
               ctrl.wr_data = rd_data;
               kept_next    = kept_ff + CNT_W'(1);
            end
            kept_in = kept_next;
            if (ptr_ff == last_ff) begin
               count_in = kept_next;
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               ctrl.rd_en   = 1'b1;
               ctrl.rd_addr = ptr_ff + IDX_W'(1);
               ptr_in       = ptr_ff + IDX_W'(1);
            end
         end

         S_RD_WAIT: begin
            fin_rd   = rd_data;
            finish   = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && !rsp_take;
      rsp_count_in      = rsp_count_ff;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      if (finish) begin
         rsp_valid_in      = 1'b1;
         rsp_count_in      = COUNT_W'(count_in);
         rsp_read_value_in = fin_rd;
         rsp_status_in     = fin_status;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      ptr_ff            <= ptr_in;
      last_ff           <= last_in;
      kept_ff           <= kept_in;
      value_ff          <= value_in;
      rsp_count_ff      <= rsp_count_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
   end

endmodule

// ----- hdl/sti_table.sv -----
// ----------------------------------------------------------------------------
// sti_table: entry store and shared comparator
// One write and one registered read per cycle; the read word is compared
// against the key of the item in progress.
// ----------------------------------------------------------------------------
module sti_table (
   input  logic                               clock,
   input  sti_pkg::tbl_ctrl_type              ctrl,
   input  logic signed [sti_pkg::VALUE_W-1:0] key,
   output logic signed [sti_pkg::VALUE_W-1:0] rd_data,
   output sti_pkg::cmp_type                   cmp
);
   import sti_pkg::*;

   logic signed [VALUE_W-1:0] entries_ff [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   // entry memory with registered read
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         entries_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= entries_ff[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   // signed compare shared by insert and delete scans
   assign cmp.less  = rd_data_ff < key;
   assign cmp.equal = rd_data_ff == key;

endmodule

// ----- hdl/sti_checker.sv -----
// ----------------------------------------------------------------------------
// sti_checker: port-level checks of the sorted table
// Watches the item channels over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sti_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [sti_pkg::VALUE_W-1:0] rsp_read_value,
   input sti_pkg::status_type                rsp_status
);
   import sti_pkg::*;

   // no result is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a held result blocks new items
   a_no_accept_while_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("item accepted while result held");

   // failed operations return zero data
   a_fail_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |-> rsp_read_value == '0)
      else $error("nonzero read value with error status");

   // a stalled result keeps its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
      else $error("stalled result changed");

endmodule

bind sorted_table_insert_delete sti_checker u_sti_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_status     (rsp_chan.status)
);

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the sorted table
// Drives insert, delete, read and no-op items through the request channel,
// moves the capacity register between phases over the register port, and
// checks each response against its typed answer or a shadow table in the bench.
// ----------------------------------------------------------------------------
module testbench;
   import sti_pkg::*;

   localparam int IDLE_PCT    = 27;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 2 * DEPTH;
   localparam logic [CSR_ADDR_W-1:0] CAP_ADDR = {CSR_REG_CAPACITY, 2'b00};
   localparam int FIXED_CAPS [4] = '{16, 31, 5, 1};
   localparam logic signed [VALUE_W-1:0] EXTREMES [4] =
      '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, 32'shFFFF_FFFF};

   typedef struct packed {
      logic [COUNT_W-1:0]        count;
      logic signed [VALUE_W-1:0] read_value;
      status_type                status;
   } sorted_answer_type;

   // answer typed into a directed row, or none
   typedef struct packed {
      logic              known;
      sorted_answer_type ans;
   } row_answer_type;

   typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_type;

   typedef struct packed {
      row_kind_type              kind;
      opcode_type                op;
      logic signed [VALUE_W-1:0] value;
      logic [INDEX_W-1:0]        index;
      row_answer_type            expect_ans;
   } step_row_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   sti_req_if req_chan ();
   sti_rsp_if rsp_chan ();

   // shadow of the block state
   logic signed [VALUE_W-1:0] shadow_entries [DEPTH];
   int                        shadow_count;
   logic [CAP_W-1:0]          shadow_capacity;

   sorted_answer_type pending_answers [$];
   row_answer_type    typed_answers [$];
   step_row_type      directed_rows [$];
   int                mismatches;
   int                cycles;
   bit                steady;

   sorted_table_insert_delete i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // apply one operation to the shadow table and return its answer
   function automatic sorted_answer_type apply_table_op(opcode_type op,
                                                        logic signed [VALUE_W-1:0] val,
                                                        logic [INDEX_W-1:0] idx);
      sorted_answer_type ans;
      int usable;
      int pos;
      int kept;
      int lim;
      int j;
      ans = '{count: '0, read_value: '0, status: STAT_OK};
      usable = (int'(shadow_capacity) < DEPTH) ? int'(shadow_capacity) : DEPTH;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= usable) begin
               ans.status = STAT_FULL;
            end else begin
               pos = 0;
               while (pos < shadow_count && shadow_entries[pos] < val) pos++;
               for (j = shadow_count; j > pos; j--) shadow_entries[j] = shadow_entries[j-1];
               shadow_entries[pos] = val;
               shadow_count++;
            end
         end
         OP_DELETE: begin
            // entries past the usable capacity are dropped
            lim = (shadow_count < usable) ? shadow_count : usable;
            kept = 0;
            for (j = 0; j < lim; j++) begin
               if (shadow_entries[j] != val) begin
                  shadow_entries[kept] = shadow_entries[j];
                  kept++;
               end
            end
            shadow_count = kept;
         end
         OP_READ: begin
            if (int'(idx) < shadow_count) ans.read_value = shadow_entries[idx];
            else ans.status = STAT_BAD_INDEX;
         end
         default: ;
      endcase
      ans.count = COUNT_W'(shadow_count);
      return ans;
   endfunction

   function automatic step_row_type plan_row(row_kind_type kind, opcode_type op,
                                             logic signed [VALUE_W-1:0] val,
                                             int idx, int known, int cnt,
                                             logic signed [VALUE_W-1:0] rd,
                                             status_type st);
      step_row_type r;
      r.kind = kind;
      r.op = op;
      r.value = val;
      r.index = INDEX_W'(idx);
      r.expect_ans = '{known: 1'(known),
                       ans: '{count: COUNT_W'(cnt), read_value: rd, status: st}};
      return r;
   endfunction

   // hand one item to the block, with random idle cycles ahead of it unless steady
   task automatic send_item(opcode_type op, logic signed [VALUE_W-1:0] val,
                            logic [INDEX_W-1:0] idx, row_answer_type typed);
      typed_answers.push_back(typed);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.value  <= val;
      req_chan.index  <= idx;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // stop sending and wait for every outstanding answer
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // register read back, bus left idle afterwards
   task automatic check_capacity(logic [CAP_W-1:0] cap);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CAP_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(cap)) begin
         $error("capacity: expected %0d, got %0d", cap, csr_prdata);
         mismatches++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // register write followed directly by a read back
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAP_ADDR;
      csr_pwdata  <= CSR_DATA_W'(cap);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      shadow_capacity = cap;
      check_capacity(cap);
   endtask

   // response ready with random stalls
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // predict on accepted items, check accepted responses, watch the cycle limit
   always @(posedge clock) begin : watch_items
      sorted_answer_type predicted;
      sorted_answer_type wanted;
      row_answer_type    typed;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("sorted_table_insert_delete verification failed");
         $finish;
      end else if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predicted = apply_table_op(req_chan.opcode, req_chan.value, req_chan.index);
            typed = (typed_answers.size() != 0) ? typed_answers.pop_front() : '0;
            pending_answers.push_back(typed.known ? typed.ans : predicted);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_answers.size() == 0) begin
               $error("response item with no request outstanding");
               mismatches++;
            end else begin
               wanted = pending_answers.pop_front();
               if (rsp_chan.count !== wanted.count) begin
                  $error("count: expected %0d, got %0d", wanted.count, rsp_chan.count);
                  mismatches++;
               end
               if (rsp_chan.read_value !== wanted.read_value) begin
                  $error("read_value: expected %h, got %h", wanted.read_value,
                         rsp_chan.read_value);
                  mismatches++;
               end
               if (rsp_chan.status !== wanted.status) begin
                  $error("status: expected %s, got %s", wanted.status.name(),
                         rsp_chan.status.name());
                  mismatches++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin : run_stimulus
      step_row_type              r;
      opcode_type                op;
      logic signed [VALUE_W-1:0] val;
      logic [INDEX_W-1:0]        idx;
      logic [CAP_W-1:0]          cap;
      int                        n_items;
      int                        ins_pct;
      int                        pick;

      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.opcode = OP_NOP;
      req_chan.value  = '0;
      req_chan.index  = '0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      mismatches      = 0;
      cycles          = 0;
      steady          = 1'b0;
      shadow_count    = 0;
      shadow_capacity = CAP_RESET;
      foreach (shadow_entries[k]) shadow_entries[k] = '0;

      // directed rows: empty table, extremes, duplicates, full and shrunk capacity
      directed_rows.push_back(plan_row(ROW_ITEM, OP_READ, 0, 0, 1, 0, 0, STAT_BAD_INDEX));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_DELETE, 5, 0, 1, 0, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_NOP, -1, 15, 1, 0, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_INSERT, EXTREMES[1], 0, 1, 1, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_INSERT, EXTREMES[0], 0, 1, 2, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_INSERT, 0, 0, 1, 3, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_INSERT, 0, 0, 1, 4, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_INSERT, -1, 0, 1, 5, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_READ, 0, 0, 1, 5, EXTREMES[0], STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_READ, 0, 4, 1, 5, EXTREMES[1], STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_READ, 0, 2, 0, 0, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_READ, 0, 5, 1, 5, 0, STAT_BAD_INDEX));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_DELETE, 0, 0, 1, 3, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_CAPACITY, OP_NOP, 3, 0, 0, 0, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_INSERT, 1, 0, 1, 3, 0, STAT_FULL));
      directed_rows.push_back(plan_row(ROW_CAPACITY, OP_NOP, 2, 0, 0, 0, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_DELETE, 42, 0, 1, 2, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_READ, 0, 1, 0, 0, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_CAPACITY, OP_NOP, 0, 0, 0, 0, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_INSERT, 7, 0, 1, 2, 0, STAT_FULL));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_DELETE, 42, 0, 1, 0, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_CAPACITY, OP_NOP, 31, 0, 0, 0, 0, STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_INSERT, 32'sh1234_5678, 0, 1, 1, 0,
                                       STAT_OK));
      directed_rows.push_back(plan_row(ROW_ITEM, OP_READ, 0, 15, 1, 1, 0, STAT_BAD_INDEX));

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_capacity(CAP_RESET);

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.kind == ROW_CAPACITY) begin
            wait_drained();
            write_capacity(CAP_W'(r.value));
         end else begin
            send_item(r.op, r.value, r.index, r.expect_ans);
         end
      end

      // random phases, each under its own capacity
      for (int p = 0; p < 8; p++) begin
         cap     = (p < 4) ? CAP_W'(FIXED_CAPS[p]) : CAP_W'($urandom_range(31, 0));
         n_items = (p == 0) ? 150 : (p == 1) ? 120 : 65;
         ins_pct = (p == 0) ? 60 : 45;
         wait_drained();
         write_capacity(cap);
         // one long stretch with no idling on either side
         steady = (p == 1);
         repeat (n_items) begin
            pick = $urandom_range(99);
            if (pick < ins_pct) op = OP_INSERT;
            else if (pick < ins_pct + (100 - ins_pct) * 2 / 5) op = OP_DELETE;
            else if (pick < 92) op = OP_READ;
            else op = OP_NOP;

            pick = $urandom_range(99);
            if (op == OP_DELETE && shadow_count > 0 && pick < 60)
               val = shadow_entries[$urandom_range(shadow_count - 1)];
            else if (pick < 40) val = int'($urandom_range(7)) - 4;
            else if (pick < 55) val = EXTREMES[$urandom_range(3)];
            else val = $urandom();

            if (shadow_count > 0 && $urandom_range(99) < 70)
               idx = INDEX_W'($urandom_range(shadow_count - 1));
            else idx = INDEX_W'($urandom_range(15));

            send_item(op, val, idx, '0);
         end
         steady = 1'b0;
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("sorted_table_insert_delete verification clean");
      end else begin
         $display("sorted_table_insert_delete verification failed");
      end
      $finish;
   end

endmodule
